// ===== rtl/core/tkd_pkg.sv =====
// tkd_pkg: shared types and constants for the two-key debounce / long-press block
// no dependencies
`timescale 1ns / 1ps

package tkd_pkg;

  localparam int unsigned DebounceW = 8;
  localparam int unsigned PollW     = 10;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [DebounceW-1:0] DebounceReset = 8'd10;
  localparam logic [PollW-1:0]     PollReset     = 10'd100;
  localparam logic [HoldW-1:0]     LongReset     = 16'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_POLL     = 2'd1,
    REG_LONG     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_DEBOUNCE = 3'b010,
    PH_HOLD     = 3'b100
  } phase_t;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ticks;
    logic [PollW-1:0]     poll_ticks;
    logic [HoldW-1:0]     long_press_ticks;
  } tkd_cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic             active_key;
    logic [PollW-1:0] wait_counter;
    logic [HoldW-1:0] hold_time;
    logic [1:0]       press_latch;
  } tkd_state_t;

  typedef struct packed {
    logic valid;
    logic key_id;
    logic long_press;
  } tkd_evt_t;

endpackage

// ===== rtl/core/tkd_cfg.sv =====
// tkd_cfg: configuration register file (debounce, poll and long-press thresholds)
// depends on tkd_pkg
`timescale 1ns / 1ps

module tkd_cfg
  import tkd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output tkd_cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DebounceReset;
      cfg.poll_ticks       <= PollReset;
      cfg.long_press_ticks <= LongReset;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE: cfg.debounce_ticks   <= wr_data[DebounceW-1:0];
        REG_POLL:     cfg.poll_ticks       <= wr_data[PollW-1:0];
        REG_LONG:     cfg.long_press_ticks <= wr_data[HoldW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/tkd_step.sv =====
// tkd_step: next-state and event logic for one tick
// depends on tkd_pkg
`timescale 1ns / 1ps

module tkd_step
  import tkd_pkg::*;
(
  input  tkd_cfg_t   cfg,
  input  tkd_state_t cur,
  input  logic       level_zero,
  input  logic       level_one,
  output tkd_state_t nxt,
  output tkd_evt_t   evt
);

  logic [PollW-1:0] wait_inc;
  logic [HoldW:0]   hold_sum;
  logic [HoldW-1:0] hold_sat;
  logic             key_level;
  logic             is_long;

  always_comb begin
    wait_inc  = cur.wait_counter + 1'b1;
    hold_sum  = {1'b0, cur.hold_time} + {{(HoldW+1-PollW){1'b0}}, cfg.poll_ticks};
    hold_sat  = hold_sum[HoldW] ? {HoldW{1'b1}} : hold_sum[HoldW-1:0];
    key_level = cur.active_key ? level_one : level_zero;
    is_long   = (hold_sat >= cfg.long_press_ticks);

    nxt = cur;
    evt = '0;

    unique case (cur.phase)
      PH_DEBOUNCE: begin
        nxt.wait_counter = wait_inc;
        if (wait_inc >= {{(PollW-DebounceW){1'b0}}, cfg.debounce_ticks}) begin
          nxt.wait_counter = '0;
          if (!key_level) begin
            nxt.press_latch[cur.active_key] = 1'b1;
            nxt.hold_time = '0;
            nxt.phase     = PH_HOLD;
          end else begin
            nxt.phase = PH_IDLE;
            // key 0 failed: key 1 gets an idle look on the same tick
            if (!cur.active_key) begin
              if (!level_one && !cur.press_latch[1]) begin
                nxt.phase      = PH_DEBOUNCE;
                nxt.active_key = 1'b1;
                nxt.wait_counter = '0;
              end else if (level_one) begin
                nxt.press_latch[1] = 1'b0;
              end
            end
          end
        end
      end
      PH_HOLD: begin
        nxt.wait_counter = wait_inc;
        if (wait_inc >= cfg.poll_ticks) begin
          nxt.wait_counter = '0;
          nxt.hold_time    = hold_sat;
          if (key_level || is_long) begin
            evt.valid      = 1'b1;
            evt.key_id     = cur.active_key;
            evt.long_press = is_long;
            nxt.phase      = PH_IDLE;
          end
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
        if (!level_zero && !cur.press_latch[0]) begin
          nxt.phase        = PH_DEBOUNCE;
          nxt.active_key   = 1'b0;
          nxt.wait_counter = '0;
        end else begin
          if (level_zero) nxt.press_latch[0] = 1'b0;
          if (!level_one && !cur.press_latch[1]) begin
            nxt.phase        = PH_DEBOUNCE;
            nxt.active_key   = 1'b1;
            nxt.wait_counter = '0;
          end else if (level_one) begin
            nxt.press_latch[1] = 1'b0;
          end
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/two_key_debounce_long_press.sv =====
// Two-key debounce and long-press detector. Each input item is one tick carrying the
// active-low levels of key 0 (bit 0) and key 1 (bit 1). One item is taken per clock;
// its effect on the debounce/hold state is computed combinationally from the state
// register, and any press event is captured in the output register. Input is accepted
// whenever the output register is empty or being drained, so the rate is one item per
// cycle unless the result side stalls. Thresholds are set through the cfg write port:
// index 0 debounce ticks, 1 poll ticks, 2 long-press ticks.
// depends on tkd_pkg, tkd_cfg, tkd_step
`timescale 1ns / 1ps

module two_key_debounce_long_press
  import tkd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [0] key_zero_level, [1] key_one_level
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [0] key_id, [1] long_press
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  tkd_cfg_t   cfg;
  tkd_state_t state;
  tkd_state_t state_next;
  tkd_evt_t   evt;
  logic       accept;
  logic       out_key_id;
  logic       out_long_press;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tkd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tkd_step u_step (
    .cfg        (cfg),
    .cur        (state),
    .level_zero (s_axis_tdata[0]),
    .level_one  (s_axis_tdata[1]),
    .nxt        (state_next),
    .evt        (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_IDLE;
      state.active_key   <= 1'b0;
      state.wait_counter <= '0;
      state.hold_time    <= '0;
      state.press_latch  <= '0;
      m_axis_tvalid      <= 1'b0;
    end else begin
      if (accept) state <= state_next;
      if (s_axis_tready) m_axis_tvalid <= accept && evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && evt.valid) begin
      out_key_id     <= evt.key_id;
      out_long_press <= evt.long_press;
    end
  end

  assign m_axis_tdata = {6'b0, out_long_press, out_key_id};

endmodule

// ===== rtl/core/tkd_checker.sv =====
// tkd_checker: port-level assertions for two_key_debounce_long_press, plus its bind
// depends on the top level
`timescale 1ns / 1ps

module tkd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_result_needs_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an accepted item");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0)
    else $error("nonzero padding in result");

endmodule

bind two_key_debounce_long_press tkd_checker u_tkd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
